// File: sv/siq_pkg.sv
// Package for the sorted intercept queue: command codes, field widths,
// fixed-point constants and the sequencer state type.
// Depends on nothing; imported by sorted_intercept_queue_core.
`timescale 1ns / 1ps

package siq_pkg;

  // Command codes carried on func_i.
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_DRAIN  = 2'd2;

  // Field widths fixed by the interface.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned DIST_IN_W  = 18;
  localparam int unsigned DIST_W     = 17;
  localparam int unsigned OBJ_PORT_W = 16;

  // 1.0 in the 16-fraction-bit distance format.
  localparam logic [DIST_W-1:0] ONE_FIXED = 17'd65536;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_WALK   = 4'b0010,
    S_PLACE0 = 4'b0100,
    S_DRAIN  = 4'b1000
  } siq_state_e;

endpackage

// File: sv/sorted_intercept_queue_core.sv
// Top level of the sorted intercept queue: command decode, insertion walk
// and drain sequencer. Depends on siq_pkg and siq_ram.
`timescale 1ns / 1ps

// Usage
// A command is transferred at a rising edge where start is high and busy
// is low. func_i selects clear, insert or drain; kind_i, distance_i and
// object_id_i carry the intercept for an insert.
// Clear and rejected or dropped inserts finish in the transfer cycle and
// leave busy low. An insert into an empty table also finishes there.
// Any other insert walks the table from the top, one stored entry per cycle
// through a single distance comparator and the one memory read port,
// shifting larger entries up by one. Busy stays high through the walk; an
// entry placed at entry 0 also goes through S_PLACE0 after the comparisons.
// A drain streams the stored entries in distance order, one per cycle, each
// through the memory read register and the output register; busy stays high
// while they are read. An empty drain gives one result in the next cycle.
// Each result is shown for one cycle with res_valid_o high; the receiver
// cannot stall, so the stream never pauses. last_o marks the final entry.
// Reset empties the table and clears the sticky overflow flag; the entry
// memory needs no clearing pass since only entries below the count are read.

module sorted_intercept_queue_core
  import siq_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned OBJECT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [FUNC_W-1:0]      func_i,
  input  logic                   kind_i,
  input  logic [DIST_IN_W-1:0]   distance_i,
  input  logic [OBJ_PORT_W-1:0]  object_id_i,
  output logic                   res_valid_o,
  output logic                   out_kind_o,
  output logic [DIST_W-1:0]      out_distance_o,
  output logic [OBJ_PORT_W-1:0]  out_object_o,
  output logic                   last_o,
  output logic                   empty_res_o,
  output logic                   overflowed_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned OBJ_W = (OBJECT_BITS < OBJ_PORT_W) ? OBJECT_BITS : OBJ_PORT_W;
  localparam int unsigned EW    = 1 + DIST_W + OBJ_W;
  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  // Entry layout: {kind, distance, object}.
  localparam int unsigned KIND_BIT = EW - 1;
  localparam int unsigned DIST_LSB = OBJ_W;

  siq_state_e         state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               ovf_q, ovf_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [EW-1:0]      new_q, new_d;
  logic               out_valid_q, out_valid_d;
  logic               out_last_q, out_last_d;
  logic               out_empty_q, out_empty_d;
  logic               out_ovf_q, out_ovf_d;
  logic [EW-1:0]      out_data_q, out_data_d;

  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  logic [EW-1:0]      ram_wr_data;
  logic               ram_rd_en;
  logic [AW-1:0]      ram_rd_addr;
  logic [EW-1:0]      ram_rd_data;

  logic               transfer;
  logic               dist_ok;
  logic [EW-1:0]      in_entry;
  logic [CW-1:0]      count_m1;
  logic [AW-1:0]      top_addr;
  logic [AW-1:0]      ptr_p1;
  logic               rd_greater;
  logic               drain_at_last;

  siq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  // Command decode and the intercept as it will be stored.
  assign transfer = start && !busy;
  assign dist_ok  = !distance_i[DIST_IN_W-1] && (distance_i[DIST_W-1:0] <= ONE_FIXED);
  assign in_entry = {kind_i, distance_i[DIST_W-1:0], object_id_i[OBJ_W-1:0]};

  // Addresses derived from the count and the walk pointer.
  assign count_m1      = count_q - CW'(1);
  assign top_addr      = count_m1[AW-1:0];
  assign ptr_p1        = ptr_q + AW'(1);
  assign drain_at_last = (CW'(ptr_q) == count_m1);

  // The walk comparator: stored entry strictly farther than the new one.
  assign rd_greater = ram_rd_data[KIND_BIT-1:DIST_LSB] > new_q[KIND_BIT-1:DIST_LSB];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    ptr_d       = ptr_q;
    new_d       = new_q;
    out_valid_d = 1'b0;
    out_last_d  = 1'b0;
    out_empty_d = 1'b0;
    out_ovf_d   = out_ovf_q;
    out_data_d  = out_data_q;
    ram_wr_en   = 1'b0;
    ram_wr_addr = ptr_p1;
    ram_wr_data = ram_rd_data;
    ram_rd_en   = 1'b0;
    ram_rd_addr = top_addr;

    case (state_q)
      S_IDLE: begin
        if (transfer) begin
          case (func_i)
            FUNC_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            FUNC_INSERT: begin
              if (dist_ok) begin
                if (count_q == FULL_COUNT) begin
                  ovf_d = 1'b1;
                end else if (count_q == '0) begin
                  // Empty table: store at entry 0 right away.
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = '0;
                  ram_wr_data = in_entry;
                  count_d     = CW'(1);
                end else begin
                  // Start the walk at the top entry.
                  new_d       = in_entry;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = top_addr;
                  ptr_d       = top_addr;
                  state_d     = S_WALK;
                end
              end
            end
            FUNC_DRAIN: begin
              if (count_q == '0) begin
                out_valid_d = 1'b1;
                out_empty_d = 1'b1;
                out_ovf_d   = 1'b0;
                out_data_d  = '0;
              end else begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                ptr_d       = '0;
                state_d     = S_DRAIN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // Read data holds entry ptr_q; a farther entry moves up one place.
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr_p1;
        if (rd_greater) begin
          ram_wr_data = ram_rd_data;
          if (ptr_q == '0) begin
            state_d = S_PLACE0;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ptr_q - AW'(1);
            ptr_d       = ptr_q - AW'(1);
          end
        end else begin
          ram_wr_data = new_q;
          count_d     = count_q + CW'(1);
          state_d     = S_IDLE;
        end
      end

      S_PLACE0: begin
        // Every stored entry was farther: the new one goes to the bottom.
        ram_wr_en   = 1'b1;
        ram_wr_addr = '0;
        ram_wr_data = new_q;
        count_d     = count_q + CW'(1);
        state_d     = S_IDLE;
      end

      S_DRAIN: begin
        // Present entry ptr_q and fetch the next one.
        out_valid_d = 1'b1;
        out_last_d  = drain_at_last;
        out_ovf_d   = ovf_q;
        out_data_d  = ram_rd_data;
        if (drain_at_last) begin
          state_d = S_IDLE;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_p1;
          ptr_d       = ptr_p1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    new_q      <= new_d;
    out_ovf_q  <= out_ovf_d;
    out_data_q <= out_data_d;
  end

  // Outputs.
  assign busy           = (state_q != S_IDLE);
  assign res_valid_o    = out_valid_q;
  assign out_kind_o     = out_data_q[KIND_BIT];
  assign out_distance_o = out_data_q[KIND_BIT-1:DIST_LSB];
  assign out_object_o   = OBJ_PORT_W'(out_data_q[OBJ_W-1:0]);
  assign last_o         = out_last_q;
  assign empty_res_o    = out_empty_q;
  assign overflowed_o   = out_ovf_q;

`ifndef SYNTHESIS
  // The count never passes the table size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_COUNT)
    else $error("entry count exceeds capacity");

  // A walk only runs when there is room for one more entry and an entry is stored.
  a_walk_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_PLACE0) |-> (count_q != FULL_COUNT && count_q != '0))
    else $error("insertion walk without room or without entries");

  // A drain in progress always has entries to stream.
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |-> (count_q != '0))
    else $error("drain sequencer running on an empty table");

  // The empty marker never comes with a last marker.
  a_empty_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_empty_q) |-> !out_last_q)
    else $error("empty result also marked last");

  // The final drain result is followed by an idle sequencer.
  a_last_ends_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && drain_at_last) |=> (state_q == S_IDLE && out_last_q))
    else $error("drain did not end on its last entry");
`endif

endmodule

// File: sv/siq_ram.sv
// Entry store of the sorted intercept queue: one write port and one
// registered read port. Depends on nothing.
`timescale 1ns / 1ps

module siq_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 34
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: tb/sorted_intercept_queue_core_test.sv
// Self-checking testbench for sorted_intercept_queue_core: directed commands,
// a full-table phase and random traffic checked against an in-bench table model.
// Depends on siq_pkg and the sorted_intercept_queue_core RTL.
`timescale 1ns / 1ps

module sorted_intercept_queue_core_test;
  import siq_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_CMDS = 215;

  // One drain output beat, in port order.
  typedef struct packed {
    logic        kind;
    logic [16:0] distance;
    logic [15:0] obj;
    logic        last;
    logic        empty;
    logic        ovf;
  } hit_result_t;

  // One directed command with an optional hand-written drain result.
  typedef struct packed {
    logic [1:0]  func;
    logic        kind;
    logic [17:0] distance;
    logic [15:0] obj;
    logic        typed;
    hit_result_t res;
  } cmd_row_t;

  localparam hit_result_t EMPTY_HIT = '{1'b0, 17'd0, 16'd0, 1'b0, 1'b1, 1'b0};
  localparam hit_result_t NO_HIT = '0;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = FUNC_CLEAR;
  logic        kind_i = 1'b0;
  logic [17:0] distance_i = '0;
  logic [15:0] object_id_i = '0;
  logic        res_valid_o;
  logic        out_kind_o;
  logic [16:0] out_distance_o;
  logic [15:0] out_object_o;
  logic        last_o;
  logic        empty_res_o;
  logic        overflowed_o;

  // Intercept table model: sorted entries, fill level and sticky overflow.
  logic        tbl_kind [CAPACITY];
  logic [16:0] tbl_dist [CAPACITY];
  logic [15:0] tbl_obj [CAPACITY];
  int          tbl_count = 0;
  logic        tbl_ovf = 1'b0;

  hit_result_t drain_expect[$];
  int          mismatch_count = 0;
  cmd_row_t    directed_rows [16];

  sorted_intercept_queue_core #(
    .CAPACITY(CAPACITY),
    .OBJECT_BITS(16)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .func_i(func_i),
    .kind_i(kind_i),
    .distance_i(distance_i),
    .object_id_i(object_id_i),
    .res_valid_o(res_valid_o),
    .out_kind_o(out_kind_o),
    .out_distance_o(out_distance_o),
    .out_object_o(out_object_o),
    .last_o(last_o),
    .empty_res_o(empty_res_o),
    .overflowed_o(overflowed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a transfer or an expected result never comes.
  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic void flag_mismatch(string what, hit_result_t want, hit_result_t seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t %s: expected kind=%0d dist=%0d obj=%0d last=%0d empty=%0d ovf=%0d",
               $realtime, what, want.kind, want.distance, want.obj, want.last, want.empty,
               want.ovf);
      $display("%0t %s:   actual kind=%0d dist=%0d obj=%0d last=%0d empty=%0d ovf=%0d",
               $realtime, what, seen.kind, seen.distance, seen.obj, seen.last, seen.empty,
               seen.ovf);
    end
  endfunction

  // Apply one accepted command to the table model and queue its drain output.
  task automatic track_command(input logic [1:0] f, input logic k, input logic [17:0] d,
                               input logic [15:0] o, input logic typed,
                               input hit_result_t typed_res);
    hit_result_t r;
    int          dv;
    int          pos;
    dv = $signed(d);
    case (f)
      FUNC_CLEAR: begin
        tbl_count = 0;
        tbl_ovf = 1'b0;
      end
      FUNC_INSERT: begin
        if (dv >= 0 && dv <= int'(ONE_FIXED)) begin
          if (tbl_count == CAPACITY) begin
            tbl_ovf = 1'b1;
          end else begin
            // Equal distances go behind existing ones so ties keep arrival order.
            pos = 0;
            while (pos < tbl_count && int'(tbl_dist[pos]) <= dv) pos++;
            for (int i = tbl_count; i > pos; i--) begin
              tbl_kind[i] = tbl_kind[i-1];
              tbl_dist[i] = tbl_dist[i-1];
              tbl_obj[i]  = tbl_obj[i-1];
            end
            tbl_kind[pos] = k;
            tbl_dist[pos] = d[16:0];
            tbl_obj[pos]  = o;
            tbl_count++;
          end
        end
      end
      FUNC_DRAIN: begin
        if (typed) begin
          drain_expect.push_back(typed_res);
        end else if (tbl_count == 0) begin
          drain_expect.push_back(EMPTY_HIT);
        end else begin
          for (int i = 0; i < tbl_count; i++) begin
            r.kind     = tbl_kind[i];
            r.distance = tbl_dist[i];
            r.obj      = tbl_obj[i];
            r.last     = (i == tbl_count - 1);
            r.empty    = 1'b0;
            r.ovf      = tbl_ovf;
            drain_expect.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Present a command and hold it until the transfer; start stays high on return.
  task automatic send_cmd(input logic [1:0] f, input logic k, input logic [17:0] d,
                          input logic [15:0] o, input logic typed, input hit_result_t res);
    start       <= 1'b1;
    func_i      <= f;
    kind_i      <= k;
    distance_i  <= d;
    object_id_i <= o;
    do @(posedge clk_i); while (busy);
    track_command(f, k, d, o, typed, res);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic sender_gap(input bit quiet);
    if (!quiet && $urandom_range(99) < 8) idle_cycles($urandom_range(1, 6));
  endtask

  // Sender stays quiet until every queued drain result has been seen.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (drain_expect.size() != 0);
  endtask

  function automatic logic [17:0] pick_distance();
    logic [17:0] d;
    case ($urandom_range(9))
      0: d = {1'b1, 17'($urandom)};
      1: d = 18'($urandom_range(65537, 131071));
      2: d = 18'($urandom_range(0, 4) * 16384);
      3: d = $urandom_range(1) ? 18'd65536 : 18'd0;
      default: d = 18'($urandom_range(0, 65536));
    endcase
    return d;
  endfunction

  // Compare every result beat against the oldest queued expectation.
  always @(posedge clk_i) begin : result_check
    hit_result_t seen;
    hit_result_t want;
    if (rst_ni && res_valid_o) begin
      seen = {out_kind_o, out_distance_o, out_object_o, last_o, empty_res_o, overflowed_o};
      if (drain_expect.size() == 0) begin
        flag_mismatch("unexpected result", NO_HIT, seen);
      end else begin
        want = drain_expect.pop_front();
        if (want.kind !== seen.kind || want.distance !== seen.distance ||
            want.obj !== seen.obj || want.last !== seen.last ||
            want.empty !== seen.empty || want.ovf !== seen.ovf) begin
          flag_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  initial begin : stimulus
    int          counted;
    logic [1:0]  f;
    logic [17:0] d;
    int          r;

    // Directed rows: extremes, ties, rejects, ignored code and empty drains.
    directed_rows[0]  = '{FUNC_DRAIN,  1'b0, 18'd0,      16'd0,      1'b1, EMPTY_HIT};
    directed_rows[1]  = '{FUNC_UNUSED, 1'b1, 18'h3FFFF,  16'hFFFF,   1'b0, NO_HIT};
    directed_rows[2]  = '{FUNC_DRAIN,  1'b1, 18'h3FFFF,  16'hFFFF,   1'b1, EMPTY_HIT};
    directed_rows[3]  = '{FUNC_INSERT, 1'b1, 18'd65536,  16'hFFFF,   1'b0, NO_HIT};
    directed_rows[4]  = '{FUNC_DRAIN,  1'b0, 18'd0,      16'd0,      1'b1,
                          '{1'b1, 17'd65536, 16'hFFFF, 1'b1, 1'b0, 1'b0}};
    directed_rows[5]  = '{FUNC_INSERT, 1'b0, 18'h3FFFF,  16'h1234,   1'b0, NO_HIT};
    directed_rows[6]  = '{FUNC_INSERT, 1'b0, 18'd65537,  16'h1235,   1'b0, NO_HIT};
    directed_rows[7]  = '{FUNC_INSERT, 1'b1, 18'h1FFFF,  16'h1236,   1'b0, NO_HIT};
    directed_rows[8]  = '{FUNC_INSERT, 1'b1, 18'h20000,  16'h1237,   1'b0, NO_HIT};
    directed_rows[9]  = '{FUNC_INSERT, 1'b0, 18'd0,      16'h0000,   1'b0, NO_HIT};
    directed_rows[10] = '{FUNC_INSERT, 1'b1, 18'd32768,  16'h0001,   1'b0, NO_HIT};
    directed_rows[11] = '{FUNC_INSERT, 1'b0, 18'd32768,  16'h0002,   1'b0, NO_HIT};
    directed_rows[12] = '{FUNC_INSERT, 1'b1, 18'd0,      16'h0003,   1'b0, NO_HIT};
    directed_rows[13] = '{FUNC_DRAIN,  1'b0, 18'd0,      16'd0,      1'b0, NO_HIT};
    directed_rows[14] = '{FUNC_CLEAR,  1'b1, 18'h2AAAA,  16'hAAAA,   1'b0, NO_HIT};
    directed_rows[15] = '{FUNC_DRAIN,  1'b0, 18'd0,      16'd0,      1'b1, EMPTY_HIT};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      sender_gap(1'b0);
      send_cmd(directed_rows[i].func, directed_rows[i].kind, directed_rows[i].distance,
               directed_rows[i].obj, directed_rows[i].typed, directed_rows[i].res);
    end
    hold_until_drained();

    // Fill the table, reject out of range while full, then overflow it.
    send_cmd(FUNC_CLEAR, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    for (int i = 0; i < CAPACITY; i++) begin
      sender_gap(1'b0);
      send_cmd(FUNC_INSERT, 1'($urandom), 18'($urandom_range(0, 8) * 8192),
               16'($urandom), 1'b0, NO_HIT);
    end
    send_cmd(FUNC_INSERT, 1'b1, 18'd70000, 16'h5555, 1'b0, NO_HIT);
    send_cmd(FUNC_DRAIN, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    send_cmd(FUNC_INSERT, 1'b0, 18'd100, 16'hBEEF, 1'b0, NO_HIT);
    send_cmd(FUNC_INSERT, 1'b1, 18'd65536, 16'hCAFE, 1'b0, NO_HIT);
    send_cmd(FUNC_DRAIN, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    send_cmd(FUNC_DRAIN, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    send_cmd(FUNC_CLEAR, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    send_cmd(FUNC_INSERT, 1'b0, 18'd1, 16'h00FF, 1'b0, NO_HIT);
    send_cmd(FUNC_DRAIN, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);
    hold_until_drained();

    // Random traffic, mostly inserts; a quiet stretch carries no sender gaps.
    counted = 0;
    while (counted < RANDOM_CMDS) begin
      r = $urandom_range(99);
      d = pick_distance();
      if (r < 3) f = FUNC_CLEAR;
      else if (r < 5) f = FUNC_UNUSED;
      else if (r < 15) f = FUNC_DRAIN;
      else f = FUNC_INSERT;
      sender_gap(counted >= 60 && counted < 140);
      send_cmd(f, 1'($urandom), d, 16'($urandom), 1'b0, NO_HIT);
      if (f != FUNC_UNUSED) counted++;
      if (counted == 170 && f != FUNC_UNUSED) hold_until_drained();
    end
    send_cmd(FUNC_DRAIN, 1'b0, 18'd0, 16'd0, 1'b0, NO_HIT);

    hold_until_drained();
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (mismatch_count == 0 && drain_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
